[hdl/strict_priority_multi_queue_macros.svh]
// Assertion macros used by the checker file of the priority queue.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_MACROS_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spmq implication check failed");

// Delayed implication: the consequent must hold after the antecedent, disabled while reset is asserted.
`define SPMQ_ASSERT_LAT2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("spmq latency check failed");

`endif

[hdl/spmq_pkg.sv]
// Types and constants shared by the strict priority queue modules.
`timescale 1ns / 1ps
`default_nettype none

package spmq_pkg;

  localparam int unsigned HandlerW  = 32;
  localparam int unsigned PayloadW  = 64;
  localparam int unsigned PrioReqW  = 4;
  localparam int unsigned PrioOutW  = 2;
  localparam int unsigned PrioCmpW  = PrioReqW + 1;

  typedef enum logic {
    OP_POST = 1'b0,
    OP_TAKE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic                vld;
    logic                take_ok;
    status_e             status;
    logic [PrioOutW-1:0] prio;
  } res_t;

endpackage

`default_nettype wire

[hdl/spmq_store.sv]
// Entry storage: one single-port memory holding handler id and payload per slot.
`timescale 1ns / 1ps
`default_nettype none

module spmq_store #(
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic                          re_i,
  input  wire logic [ADDR_W-1:0]             addr_i,
  input  wire logic [spmq_pkg::HandlerW-1:0] handler_i,
  input  wire logic [spmq_pkg::PayloadW-1:0] payload_i,
  output logic      [spmq_pkg::HandlerW-1:0] handler_o,
  output logic      [spmq_pkg::PayloadW-1:0] payload_o
);

  localparam int unsigned Depth = 2 ** ADDR_W;
  localparam int unsigned DataW = spmq_pkg::HandlerW + spmq_pkg::PayloadW;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= {handler_i, payload_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem[addr_i];
    end
  end

  assign handler_o = rd_q[DataW-1:spmq_pkg::PayloadW];
  assign payload_o = rd_q[spmq_pkg::PayloadW-1:0];

endmodule

`default_nettype wire

[hdl/spmq_ctrl.sv]
// Ring pointers, post and take decisions, and the registered result status.
`timescale 1ns / 1ps
`default_nettype none

module spmq_ctrl #(
  parameter int unsigned LEVELS     = 4,
  parameter int unsigned RING_SLOTS = 16,
  parameter int unsigned PTR_W      = 4,
  parameter int unsigned LVL_W      = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_vld_i,
  input  wire spmq_pkg::opcode_e             opcode_i,
  input  wire logic [spmq_pkg::HandlerW-1:0] handler_id_i,
  input  wire logic [spmq_pkg::PrioReqW-1:0] priority_req_i,
  output logic                               store_we_o,
  output logic                               store_re_o,
  output logic      [LVL_W+PTR_W-1:0]        store_addr_o,
  output spmq_pkg::res_t                     res_o
);

  logic [PTR_W-1:0] rp_q [LEVELS];
  logic [PTR_W-1:0] wp_q [LEVELS];
  logic [PTR_W-1:0] rp_inc [LEVELS];
  logic [PTR_W-1:0] wp_inc [LEVELS];
  logic [LEVELS-1:0] nonempty;
  logic [LEVELS-1:0] full;
  logic [LEVELS-1:0] post_sel;
  logic [LEVELS-1:0] take_sel;
  logic              seen;
  logic [LVL_W-1:0]  post_lvl;
  logic [PTR_W-1:0]  post_ptr;
  logic [LVL_W-1:0]  take_lvl;
  logic [PTR_W-1:0]  take_ptr;
  logic              is_take;
  logic              handler_zero;
  logic              prio_bad;
  logic              post_full;
  logic              post_ok;
  logic              take_ok;
  spmq_pkg::res_t    res_d;
  spmq_pkg::res_t    res_q;

  always_comb begin
    seen     = 1'b0;
    post_lvl = '0;
    post_ptr = '0;
    take_lvl = '0;
    take_ptr = '0;
    for (int l = 0; l < LEVELS; l++) begin
      rp_inc[l]   = (rp_q[l] == PTR_W'(RING_SLOTS - 1)) ? '0 : rp_q[l] + 1'b1;
      wp_inc[l]   = (wp_q[l] == PTR_W'(RING_SLOTS - 1)) ? '0 : wp_q[l] + 1'b1;
      nonempty[l] = (rp_q[l] != wp_q[l]);
      full[l]     = (wp_inc[l] == rp_q[l]);
      post_sel[l] = (priority_req_i == spmq_pkg::PrioReqW'(l));
      take_sel[l] = nonempty[l] && !seen;
      seen        = seen | nonempty[l];
      if (post_sel[l]) begin
        post_lvl = LVL_W'(l);
        post_ptr = wp_q[l];
      end
      if (take_sel[l]) begin
        take_lvl = LVL_W'(l);
        take_ptr = rp_q[l];
      end
    end
  end

  always_comb begin
    is_take      = (opcode_i == spmq_pkg::OP_TAKE);
    handler_zero = (handler_id_i == '0);
    prio_bad     = ({1'b0, priority_req_i} >= spmq_pkg::PrioCmpW'(LEVELS));
    post_full    = |(post_sel & full);
    post_ok      = item_vld_i && !is_take && !handler_zero && !prio_bad && !post_full;
    take_ok      = item_vld_i && is_take && seen;
  end

  always_comb begin
    store_we_o   = post_ok;
    store_re_o   = take_ok;
    store_addr_o = is_take ? {take_lvl, take_ptr} : {post_lvl, post_ptr};
  end

  always_comb begin
    res_d.vld     = item_vld_i;
    res_d.take_ok = take_ok;
    res_d.prio    = take_ok ? spmq_pkg::PrioOutW'(take_lvl) : '0;
    if (is_take) begin
      res_d.status = seen ? spmq_pkg::ST_OK : spmq_pkg::ST_EMPTY;
    end else if (handler_zero || prio_bad) begin
      res_d.status = spmq_pkg::ST_INVALID;
    end else if (post_full) begin
      res_d.status = spmq_pkg::ST_FULL;
    end else begin
      res_d.status = spmq_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        rp_q[l] <= '0;
        wp_q[l] <= '0;
      end
      res_q <= spmq_pkg::res_t'(0);
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (post_ok && post_sel[l]) begin
          wp_q[l] <= wp_inc[l];
        end
        if (take_ok && take_sel[l]) begin
          rp_q[l] <= rp_inc[l];
        end
      end
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[hdl/strict_priority_multi_queue.sv]
// Top level of the strict priority event queue with one ring per level.
//
//   Channel   Handshake              Fields
//   command   start_i / busy_o       opcode_i, handler_id_i, payload_i, priority_req_i
//   result    done_o (strobe)        status_o, handler_out_o, payload_out_o, priority_out_o
//
// One item is accepted every cycle; busy_o stays low.
// Each result passes the input register and the result register, then shows for one cycle, in accept order.
// The pointer update and the single memory access happen in the cycle after accept.
// Reset clears all ring pointers, so every ring is empty afterwards; no clearing pass.
// The receiver cannot stall, so there is no backpressure path.
`timescale 1ns / 1ps
`default_nettype none

module strict_priority_multi_queue #(
  parameter int unsigned LEVELS     = 4,
  parameter int unsigned RING_SLOTS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          opcode_i,
  input  wire logic [spmq_pkg::HandlerW-1:0] handler_id_i,
  input  wire logic [spmq_pkg::PayloadW-1:0] payload_i,
  input  wire logic [spmq_pkg::PrioReqW-1:0] priority_req_i,
  output logic                               done_o,
  output logic      [1:0]                    status_o,
  output logic      [spmq_pkg::HandlerW-1:0] handler_out_o,
  output logic      [spmq_pkg::PayloadW-1:0] payload_out_o,
  output logic      [spmq_pkg::PrioOutW-1:0] priority_out_o
);

  localparam int unsigned PtrW  = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
  localparam int unsigned LvlW  = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int unsigned AddrW = LvlW + PtrW;

  logic                          vld_q;
  spmq_pkg::opcode_e             op_q;
  logic [spmq_pkg::HandlerW-1:0] hid_q;
  logic [spmq_pkg::PayloadW-1:0] pay_q;
  logic [spmq_pkg::PrioReqW-1:0] prio_q;
  logic                          accept;
  logic                          store_we;
  logic                          store_re;
  logic [AddrW-1:0]              store_addr;
  logic [spmq_pkg::HandlerW-1:0] rd_handler;
  logic [spmq_pkg::PayloadW-1:0] rd_payload;
  spmq_pkg::res_t                res;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= spmq_pkg::opcode_e'(opcode_i);
      hid_q  <= handler_id_i;
      pay_q  <= payload_i;
      prio_q <= priority_req_i;
    end
  end

  spmq_ctrl #(
    .LEVELS     (LEVELS),
    .RING_SLOTS (RING_SLOTS),
    .PTR_W      (PtrW),
    .LVL_W      (LvlW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_vld_i     (vld_q),
    .opcode_i       (op_q),
    .handler_id_i   (hid_q),
    .priority_req_i (prio_q),
    .store_we_o     (store_we),
    .store_re_o     (store_re),
    .store_addr_o   (store_addr),
    .res_o          (res)
  );

  spmq_store #(
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .re_i      (store_re),
    .addr_i    (store_addr),
    .handler_i (hid_q),
    .payload_i (pay_q),
    .handler_o (rd_handler),
    .payload_o (rd_payload)
  );

  assign done_o         = res.vld;
  assign status_o       = res.status;
  assign handler_out_o  = res.take_ok ? rd_handler : '0;
  assign payload_out_o  = res.take_ok ? rd_payload : '0;
  assign priority_out_o = res.prio;

endmodule

`default_nettype wire

[hdl/spmq_chk.sv]
// Port-level checker for the strict priority queue and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "strict_priority_multi_queue_macros.svh"

module spmq_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic                          done_o,
  input wire logic [1:0]                    status_o,
  input wire logic [spmq_pkg::HandlerW-1:0] handler_out_o,
  input wire logic [spmq_pkg::PayloadW-1:0] payload_out_o,
  input wire logic [spmq_pkg::PrioOutW-1:0] priority_out_o
);

  `SPMQ_ASSERT_LAT2(a_item_gives_result, clk_i, rst_ni, start_i && !busy_o, done_o)

  `SPMQ_ASSERT_IMP(a_result_has_item, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 2))

  `SPMQ_ASSERT_IMP(a_fail_zero_fields, clk_i, rst_ni, done_o && (status_o != spmq_pkg::ST_OK), (handler_out_o == '0) && (payload_out_o == '0) && (priority_out_o == '0))

  `SPMQ_ASSERT_IMP(a_take_has_handler, clk_i, rst_ni, done_o && (priority_out_o != '0), handler_out_o != '0)

endmodule

bind strict_priority_multi_queue spmq_chk u_spmq_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .status_o       (status_o),
  .handler_out_o  (handler_out_o),
  .payload_out_o  (payload_out_o),
  .priority_out_o (priority_out_o)
);

`default_nettype wire
